FILE: src/bpmq_pkg.sv
// Shared definitions for the banked priority message queue.
// Field widths, operation and status codes, parameter defaults, cell control.
// No dependencies.
package bpmq_pkg;

    // Fixed field widths of the transfer channels
    localparam int OP_W     = 2;
    localparam int QID_W    = 3;
    localparam int PRIO_W   = 8;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Parameter defaults
    localparam int QUEUES_DEF       = 8;
    localparam int SLOTS_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic rd_en;   // read the addressed queue's slot
        logic wr_ins;  // commit an insert
        logic wr_pop;  // commit a pop
    } cell_ctl_t;

endpackage

FILE: src/bpmq_if.sv
// Transfer channel interfaces for the banked priority message queue.
// Request and response channels with valid/ready handshake.
// Depends on bpmq_pkg.
interface bpmq_req_if;
    import bpmq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [QID_W-1:0]  queue_id;
    logic [PRIO_W-1:0] priority_req;
    logic [WORD_W-1:0] payload;

    modport source (output valid, op, queue_id, priority_req, payload, input ready);
    modport sink   (input valid, op, queue_id, priority_req, payload, output ready);
endinterface

interface bpmq_rsp_if;
    import bpmq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   head_priority;
    logic [WORD_W-1:0]   head_payload;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, status, head_priority, head_payload, fill_count,
                    input ready);
    modport sink   (input valid, status, head_priority, head_payload, fill_count,
                    output ready);
endinterface

FILE: src/bpmq_cell.sv
// One slot cell: holds slot IDX of every queue in a small per-queue memory.
// Compares against the new priority and takes data from either neighbour.
// Depends on bpmq_pkg.
module bpmq_cell #(
    parameter int QUEUES       = bpmq_pkg::QUEUES_DEF,
    parameter int SLOTS        = bpmq_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BITS = bpmq_pkg::PAYLOAD_BITS_DEF,
    parameter int IDX          = 0,
    localparam int QW          = (QUEUES > 1) ? $clog2(QUEUES) : 1,
    localparam int CW          = $clog2(SLOTS + 1)
) (
    input  logic                          clk,
    input  bpmq_pkg::cell_ctl_t           ctl,
    input  logic [QW-1:0]                 rd_addr,
    input  logic [QW-1:0]                 wr_addr,
    input  logic [CW-1:0]                 count,
    input  logic [bpmq_pkg::PRIO_W-1:0]   new_prio,
    input  logic [PAYLOAD_BITS-1:0]       new_word,
    input  logic                          prev_ge,
    input  logic [bpmq_pkg::PRIO_W-1:0]   prev_prio,
    input  logic [PAYLOAD_BITS-1:0]       prev_word,
    input  logic [bpmq_pkg::PRIO_W-1:0]   next_prio,
    input  logic [PAYLOAD_BITS-1:0]       next_word,
    output logic [bpmq_pkg::PRIO_W-1:0]   cur_prio,
    output logic [PAYLOAD_BITS-1:0]       cur_word,
    output logic                          cur_ge
);
    import bpmq_pkg::*;

    logic [PRIO_W-1:0]       prio_mem [QUEUES];
    logic [PAYLOAD_BITS-1:0] word_mem [QUEUES];
    logic [PRIO_W-1:0]       prio_rd_reg;
    logic [PAYLOAD_BITS-1:0] word_rd_reg;
    logic                    occupied;
    logic                    wr_en;
    logic [PRIO_W-1:0]       wr_prio;
    logic [PAYLOAD_BITS-1:0] wr_word;

    // Entry stays ahead of the new one when occupied and not lower priority
    assign occupied = count > CW'(IDX);
    assign cur_ge   = occupied && (prio_rd_reg >= new_prio);
    assign cur_prio = prio_rd_reg;
    assign cur_word = word_rd_reg;

    // Insert: first cell past the run of kept entries takes the new one,
    // later cells take their left neighbour. Pop: take the right neighbour.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_prio = next_prio;
        wr_word = next_word;
        if (ctl.wr_ins && !cur_ge)
        begin
            wr_en = 1'b1;
            if (prev_ge)
            begin
                wr_prio = new_prio;
                wr_word = new_word;
            end
            else
            begin
                wr_prio = prev_prio;
                wr_word = prev_word;
            end
        end
        else if (ctl.wr_pop)
        begin
            wr_en = 1'b1;
        end
    end

    // Per-queue store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prio_mem[wr_addr] <= wr_prio;
            word_mem[wr_addr] <= wr_word;
        end
        if (ctl.rd_en)
        begin
            prio_rd_reg <= prio_mem[rd_addr];
            word_rd_reg <= word_mem[rd_addr];
        end
    end

endmodule

FILE: src/banked_priority_message_queue.sv
// Banked priority message queue: QUEUES queues of up to SLOTS sorted entries.
// Request transfers carry op, queue_id, priority_req and payload; each request
// gives exactly one response transfer with status, head fields and fill count.
// The storage is a row of SLOTS cells; cell i keeps slot i of every queue in a
// per-queue memory, so every slot of the addressed queue is seen at once.
// Timing: a request is taken while the cells and the count store read the
// addressed queue; in the execute step the cells compare, shift and write back
// and the response is registered. The response is valid from the cycle after
// that, and the next request can be taken then: the block takes no new request
// until the last one is done, since the per-queue stores have a registered read.
// A finished response waits in the output register while the next request is
// taken; if it is still not taken when that request completes, the block holds
// that request in its execute step (and keeps ready low) until the output frees.
// Reset clears all fill counts through per-queue valid flags; no clearing pass
// is needed and entries are only ever read below a queue's count.
// Depends on bpmq_pkg, bpmq_if and bpmq_cell.
module banked_priority_message_queue #(
    parameter int QUEUES       = bpmq_pkg::QUEUES_DEF,
    parameter int SLOTS        = bpmq_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BITS = bpmq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bpmq_req_if.sink   req,
    bpmq_rsp_if.source rsp
);
    import bpmq_pkg::*;

    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (QW > QID_W) ? QW : QID_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [OP_W-1:0]         op_reg;
    logic [PRIO_W-1:0]       prio_reg;
    logic [PAYLOAD_BITS-1:0] word_reg;
    logic [QW-1:0]           addr_reg;
    logic                    inr_reg;
    logic [CW-1:0]           cnt_rd_reg;
    logic                    cvld_rd_reg;
    logic [CW-1:0]           count_mem [QUEUES];
    logic [QUEUES-1:0]       cvld_reg;

    logic                    rsp_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [PRIO_W-1:0]       hprio_reg;
    logic [WORD_W-1:0]       hword_reg;
    logic [FILL_W-1:0]       fill_reg;

    logic                    accept;
    logic                    commit;
    logic [AW-1:0]           qid_ext;
    logic                    in_range;
    logic [QW-1:0]           rd_addr;
    logic [CW-1:0]           count;
    logic [STATUS_W-1:0]     res_status;
    logic                    res_head;
    logic [CW-1:0]           res_fill;
    logic                    do_ins;
    logic                    do_pop;
    cell_ctl_t               ctl;

    logic [PRIO_W-1:0]       cell_prio [SLOTS];
    logic [PAYLOAD_BITS-1:0] cell_word [SLOTS];
    logic                    ge_chain  [SLOTS+1];

    // Handshake
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Queue address
    assign qid_ext  = AW'(req.queue_id);
    assign rd_addr  = qid_ext[QW-1:0];
    assign in_range = {1'b0, qid_ext} < (AW+1)'(QUEUES);
    assign count    = cvld_rd_reg ? cnt_rd_reg : '0;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            prio_reg <= req.priority_req;
            word_reg <= req.payload[PAYLOAD_BITS-1:0];
            addr_reg <= rd_addr;
            inr_reg  <= in_range;
        end
    end

    // Operation decode and result
    always_comb
    begin
        res_status = ST_OK;
        res_head   = 1'b0;
        res_fill   = count;
        do_ins     = 1'b0;
        do_pop     = 1'b0;
        if (!inr_reg)
        begin
            res_fill = '0;
            case (op_reg)
                OP_INSERT:         res_status = ST_FULL;
                OP_PEEK, OP_POP:   res_status = ST_EMPTY;
                default:           res_status = ST_OK;
            endcase
        end
        else
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    if (count == CW'(SLOTS))
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        do_ins   = 1'b1;
                        res_fill = count + CW'(1);
                    end
                end
                OP_PEEK:
                begin
                    if (count == '0)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        res_head = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (count == '0)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        do_pop   = 1'b1;
                        res_fill = count - CW'(1);
                    end
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    assign ctl.rd_en  = accept;
    assign ctl.wr_ins = commit && do_ins;
    assign ctl.wr_pop = commit && do_pop;

    // Fill count store: memory with registered read, valid flags in flops
    always_ff @(posedge clk)
    begin
        if (commit && inr_reg)
        begin
            count_mem[addr_reg] <= res_fill;
        end
        if (accept)
        begin
            cnt_rd_reg <= count_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvld_reg    <= '0;
            cvld_rd_reg <= 1'b0;
        end
        else
        begin
            if (commit && inr_reg)
            begin
                cvld_reg[addr_reg] <= 1'b1;
            end
            if (accept)
            begin
                cvld_rd_reg <= cvld_reg[rd_addr];
            end
        end
    end

    // Row of slot cells
    assign ge_chain[0] = 1'b1;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic [PRIO_W-1:0]       prev_prio;
        logic [PAYLOAD_BITS-1:0] prev_word;
        logic [PRIO_W-1:0]       next_prio;
        logic [PAYLOAD_BITS-1:0] next_word;

        if (i == 0)
        begin : g_first
            assign prev_prio = '0;
            assign prev_word = '0;
        end
        else
        begin : g_mid
            assign prev_prio = cell_prio[i-1];
            assign prev_word = cell_word[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_last
            assign next_prio = '0;
            assign next_word = '0;
        end
        else
        begin : g_body
            assign next_prio = cell_prio[i+1];
            assign next_word = cell_word[i+1];
        end

        bpmq_cell #(
            .QUEUES       (QUEUES),
            .SLOTS        (SLOTS),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .IDX          (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .rd_addr   (rd_addr),
            .wr_addr   (addr_reg),
            .count     (count),
            .new_prio  (prio_reg),
            .new_word  (word_reg),
            .prev_ge   (ge_chain[i]),
            .prev_prio (prev_prio),
            .prev_word (prev_word),
            .next_prio (next_prio),
            .next_word (next_word),
            .cur_prio  (cell_prio[i]),
            .cur_word  (cell_word[i]),
            .cur_ge    (ge_chain[i+1])
        );
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg <= res_status;
            hprio_reg  <= res_head ? cell_prio[0] : '0;
            hword_reg  <= res_head ? WORD_W'(cell_word[0]) : '0;
            fill_reg   <= FILL_W'(res_fill);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.head_priority = hprio_reg;
    assign rsp.head_payload  = hword_reg;
    assign rsp.fill_count    = fill_reg;

    // Checks
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while another is in flight");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (res_fill <= CW'(SLOTS)))
        else $error("fill count beyond queue depth");

    a_full_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (res_status == ST_FULL)) |-> (op_reg == OP_INSERT))
        else $error("full status on an operation other than insert");

    a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> ((rsp.head_priority == '0)
            && (rsp.head_payload == '0)))
        else $error("head fields set on a failed operation");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr_ins && ctl.wr_pop))
        else $error("insert and pop committed together");

endmodule

FILE: tb/tb_banked_priority_message_queue.sv
// Self-checking testbench for banked_priority_message_queue.
// Drives request transfers, predicts each response from its own queue model, checks in order.
// Depends on bpmq_pkg, bpmq_if and the block's RTL.
module tb_banked_priority_message_queue;
    import bpmq_pkg::*;

    localparam int N_QUEUES       = QUEUES_DEF;
    localparam int N_SLOTS        = SLOTS_DEF;
    localparam int N_PAYLOAD_BITS = PAYLOAD_BITS_DEF;
    localparam int CYCLE_LIMIT    = 200000;

    // Op code 3 has no name in the package; the block treats it as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - N_PAYLOAD_BITS);

    // Traffic mixes for the random part
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_BLEND = 2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PRIO_W-1:0]   head_priority;
        logic [WORD_W-1:0]   head_payload;
        logic [FILL_W-1:0]   fill_count;
    } queue_rsp_t;

    logic clk;
    logic rst_n;

    bpmq_req_if req_ch ();
    bpmq_rsp_if rsp_ch ();

    banked_priority_message_queue #(
        .QUEUES      (N_QUEUES),
        .SLOTS       (N_SLOTS),
        .PAYLOAD_BITS(N_PAYLOAD_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .rsp  (rsp_ch.source)
    );

    // Queue model: sorted entries per queue and their fill
    logic [PRIO_W-1:0] model_prio [N_QUEUES][N_SLOTS];
    logic [WORD_W-1:0] model_word [N_QUEUES][N_SLOTS];
    int unsigned       model_fill [N_QUEUES];

    queue_rsp_t rsp_expected [$];

    int error_count;
    int sent_count;
    int checked_count;
    int full_seen;
    int empty_seen;
    int head_seen;
    int cycle_count;
    int rsp_hold_left;
    int rsp_stall_left;
    bit gaps_on;
    int hot_a;
    int hot_b;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one operation to the queue model and return the response it gives
    function automatic queue_rsp_t apply_queue_op(input logic [OP_W-1:0] op,
                                                  input logic [QID_W-1:0] qid,
                                                  input logic [PRIO_W-1:0] prio,
                                                  input logic [WORD_W-1:0] word);
        queue_rsp_t  r;
        int unsigned n;
        int unsigned pos;
        int          j;
        r = '0;
        if (qid >= N_QUEUES)
        begin
            if (op == OP_INSERT)
                r.status = ST_FULL;
            else if (op == OP_PEEK || op == OP_POP)
                r.status = ST_EMPTY;
            return r;
        end
        n = model_fill[qid];
        case (op)
            OP_INSERT:
            begin
                if (n >= N_SLOTS)
                begin
                    r.status     = ST_FULL;
                    r.fill_count = FILL_W'(n);
                end
                else
                begin
                    // New entry goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < n && model_prio[qid][pos] >= prio)
                        pos++;
                    for (j = n; j > pos; j--)
                    begin
                        model_prio[qid][j] = model_prio[qid][j-1];
                        model_word[qid][j] = model_word[qid][j-1];
                    end
                    model_prio[qid][pos] = prio;
                    model_word[qid][pos] = word & WORD_MASK;
                    model_fill[qid]      = n + 1;
                    r.status             = ST_OK;
                    r.fill_count         = FILL_W'(n + 1);
                end
            end
            OP_PEEK:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status        = ST_OK;
                    r.head_priority = model_prio[qid][0];
                    r.head_payload  = model_word[qid][0] & WORD_MASK;
                    r.fill_count    = FILL_W'(n);
                end
            end
            OP_POP:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (j = 0; j < n - 1; j++)
                    begin
                        model_prio[qid][j] = model_prio[qid][j+1];
                        model_word[qid][j] = model_word[qid][j+1];
                    end
                    model_fill[qid] = n - 1;
                    r.status        = ST_OK;
                    r.fill_count    = FILL_W'(n - 1);
                end
            end
            default:
            begin
                r.status     = ST_OK;
                r.fill_count = FILL_W'(n);
            end
        endcase
        return r;
    endfunction

    // Offer one request, wait for its transfer, then record the predicted response
    task automatic send_request(input logic [OP_W-1:0] op, input logic [QID_W-1:0] qid,
                                input logic [PRIO_W-1:0] prio, input logic [WORD_W-1:0] word);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.queue_id     <= qid;
        req_ch.priority_req <= prio;
        req_ch.payload      <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        rsp_expected.push_back(apply_queue_op(op, qid, prio, word));
        sent_count++;
    endtask

    function automatic logic [OP_W-1:0] pick_op(input int mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return OP_UNUSED;
        case (mix)
            MIX_FILL:  return roll < 70 ? OP_INSERT : (roll < 82 ? OP_PEEK : OP_POP);
            MIX_DRAIN: return roll < 25 ? OP_INSERT : (roll < 40 ? OP_PEEK : OP_POP);
            default:   return roll < 45 ? OP_INSERT : (roll < 70 ? OP_PEEK : OP_POP);
        endcase
    endfunction

    // Ties are common so that arrival order among equal priorities is exercised
    function automatic logic [PRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 5))
            0, 1:    return PRIO_W'($urandom_range(0, 3));
            2:       return $urandom_range(0, 1) ? {PRIO_W{1'b1}} : {PRIO_W{1'b0}};
            3:       return PRIO_W'($urandom_range(250, 255));
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    task automatic send_random_item(input int mix);
        logic [QID_W-1:0] qid;
        case ($urandom_range(0, 7))
            0, 1, 2: qid = QID_W'(hot_a);
            3, 4, 5: qid = QID_W'(hot_b);
            default: qid = QID_W'($urandom_range(0, (1 << QID_W) - 1));
        endcase
        send_request(pick_op(mix), qid, pick_priority(), {$urandom, $urandom});
    endtask

    // Operations on a queue that has never been written
    task automatic test_empty_queue();
        send_request(OP_PEEK, 3'd7, 8'hff, {WORD_W{1'b1}});
        send_request(OP_POP, 3'd7, 8'h00, '0);
        send_request(OP_UNUSED, 3'd7, 8'h5a, 64'h0123_4567_89ab_cdef);
    endtask

    // Extreme priorities, ties kept in arrival order, head replaced after pop
    task automatic test_priority_order();
        send_request(OP_INSERT, 3'd5, 8'h00, '0);
        send_request(OP_INSERT, 3'd5, 8'hff, {WORD_W{1'b1}});
        send_request(OP_INSERT, 3'd5, 8'h80, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(OP_INSERT, 3'd5, 8'h80, 64'h5555_5555_5555_5555);
        send_request(OP_PEEK, 3'd5, 8'h00, '0);
        send_request(OP_POP, 3'd5, 8'h00, '0);
        send_request(OP_PEEK, 3'd5, 8'h00, '0);
    endtask

    // Top up the same queue until full, then insert once more
    task automatic test_full_queue();
        while (model_fill[5] < N_SLOTS)
            send_request(OP_INSERT, 3'd5, pick_priority(), {$urandom, $urandom});
        send_request(OP_INSERT, 3'd5, 8'hff, {WORD_W{1'b1}});
        send_request(OP_UNUSED, 3'd5, 8'h00, '0);
    endtask

    // Phases of differing mix, hot queues and idling
    task automatic test_random_traffic(input int items);
        int mix;
        for (int i = 0; i < items; i++)
        begin
            if (i % 30 == 0)
            begin
                mix     = $urandom_range(MIX_FILL, MIX_BLEND);
                hot_a   = $urandom_range(0, N_QUEUES - 1);
                hot_b   = $urandom_range(0, N_QUEUES - 1);
                gaps_on = $urandom_range(0, 4) != 0;
            end
            send_random_item(mix);
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_output_backpressure(input int items);
        gaps_on       = 1'b0;
        hot_a         = 1;
        hot_b         = 6;
        rsp_hold_left = 150;
        for (int i = 0; i < items; i++)
            send_random_item(MIX_BLEND);
    endtask

    // Full rate on both sides to the end
    task automatic test_back_to_back(input int items);
        gaps_on = 1'b0;
        for (int i = 0; i < items; i++)
        begin
            if (i % 20 == 0)
            begin
                hot_a = $urandom_range(0, N_QUEUES - 1);
                hot_b = $urandom_range(0, N_QUEUES - 1);
            end
            send_random_item(i < items / 2 ? MIX_FILL : MIX_DRAIN);
        end
    endtask

    task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Response side: check each transfer against the oldest prediction, then pick ready
    always @(posedge clk)
    begin
        queue_rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $display("%0t: response with none expected, actual status %0h fill %0d",
                             $time, rsp_ch.status, rsp_ch.fill_count);
                    error_count++;
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(rsp_ch.status));
                    check_field("head_priority", WORD_W'(want.head_priority),
                                WORD_W'(rsp_ch.head_priority));
                    check_field("head_payload", want.head_payload, rsp_ch.head_payload);
                    check_field("fill_count", WORD_W'(want.fill_count),
                                WORD_W'(rsp_ch.fill_count));
                    checked_count++;
                    if (want.status == ST_FULL)
                        full_seen++;
                    if (want.status == ST_EMPTY)
                        empty_seen++;
                    if (want.status == ST_OK && want.head_priority != 0)
                        head_seen++;
                end
            end
            if (rsp_hold_left > 0)
            begin
                rsp_hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_stall_left > 0)
            begin
                rsp_stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                rsp_stall_left = $urandom_range(1, 12) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding", $time, rsp_expected.size());
            $display("tb_banked_priority_message_queue: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_INSERT;
        req_ch.queue_id     = '0;
        req_ch.priority_req = '0;
        req_ch.payload      = '0;
        rsp_ch.ready        = 1'b0;
        error_count         = 0;
        sent_count          = 0;
        checked_count       = 0;
        full_seen           = 0;
        empty_seen          = 0;
        head_seen           = 0;
        cycle_count         = 0;
        rsp_hold_left       = 0;
        rsp_stall_left      = 0;
        gaps_on             = 1'b1;
        hot_a               = 0;
        hot_b               = 0;
        for (int q = 0; q < N_QUEUES; q++)
        begin
            model_fill[q] = 0;
            for (int s = 0; s < N_SLOTS; s++)
            begin
                model_prio[q][s] = '0;
                model_word[q][s] = '0;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_priority_order();
        test_full_queue();
        test_random_traffic(330);
        test_output_backpressure(40);
        test_back_to_back(80);

        req_ch.valid <= 1'b0;
        while (rsp_expected.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests, checked %0d responses over %0d cycles.",
                 sent_count, checked_count, cycle_count);
        $display("Full refusals %0d, empty reports %0d, non-zero head peeks %0d.",
                 full_seen, empty_seen, head_seen);
        if (error_count == 0)
            $display("tb_banked_priority_message_queue: clean");
        else
            $display("tb_banked_priority_message_queue: errors");
        $finish;
    end

endmodule
